// File: rtl/multichannel_pulse_with_lockout_macros.svh
// Assertion macros shared by the pulse generator RTL.
`ifndef MULTICHANNEL_PULSE_WITH_LOCKOUT_MACROS_SVH
`define MULTICHANNEL_PULSE_WITH_LOCKOUT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, off during reset.
`define MPL_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pulse generator check failed");
// Next-cycle implication, sampled on clk, off during reset.
`define MPL_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pulse generator check failed");
`else
`define MPL_ASSERT_IMP(label, ante, cons)
`define MPL_ASSERT_NXT(label, ante, cons)
`endif
`endif

// File: rtl/mpl_pkg.sv
// Shared types, constants and helper functions of the pulse generator.
`default_nettype none
package mpl_pkg;

    localparam int CHANNELS = 8;
    localparam int TICK_W   = 16;

    localparam logic [TICK_W-1:0] TICK_SAT  = 16'd60000;
    localparam logic [TICK_W-1:0] ON_RESET  = 16'd1000;
    localparam logic [TICK_W-1:0] OFF_RESET = 16'd9000;

    typedef logic [TICK_W-1:0] tick_t;

    // Request codes carried in the input tuser.
    typedef enum logic [2:0] {
        ACT_TICK     = 3'd0,
        ACT_FIRE     = 3'd1,
        ACT_STOP     = 3'd2,
        ACT_SET      = 3'd3,
        ACT_SET_ALL  = 3'd4,
        ACT_FIRE_ALL = 3'd5,
        ACT_STOP_ALL = 3'd6
    } action_t;

    // Per-channel operation decoded from the request.
    typedef enum logic [2:0] {
        CH_NONE,
        CH_TICK,
        CH_FIRE,
        CH_STOP,
        CH_SET,
        CH_SET_IDLE
    } chan_op_t;

    typedef struct packed {
        chan_op_t op;
        tick_t    now;
        tick_t    on_ticks;
        tick_t    off_ticks;
    } chan_cmd_t;

    // Clamp a time to the longest allowed interval.
    function automatic tick_t sat_ticks(tick_t v);
        return (v > TICK_SAT) ? TICK_SAT : v;
    endfunction

    // Wrap-aware "a has reached b": sign bit of a - b is clear.
    function automatic logic reached(tick_t a, tick_t b);
        tick_t d;
        d = a - b;
        return ~d[TICK_W-1];
    endfunction

endpackage
`default_nettype wire

// File: rtl/mpl_chan.sv
// One output channel: pulse state, hold-off and timing of that channel.
`default_nettype none
module mpl_chan (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire mpl_pkg::chan_cmd_t cmd,
    output logic                   active_next,
    output logic                   fire_ok
);
    import mpl_pkg::*;

    logic  active_reg;
    tick_t end_reg, end_next;
    tick_t hold_reg, hold_next;
    tick_t on_reg, on_next;
    tick_t off_reg, off_next;
    tick_t fire_end;

    assign fire_end = cmd.now + sat_ticks(on_reg);
    assign fire_ok  = (cmd.op == CH_FIRE) && reached(cmd.now, hold_reg);

    // Work out the next channel state for the current request.
    always_comb
    begin
        active_next = active_reg;
        end_next    = end_reg;
        hold_next   = hold_reg;
        on_next     = on_reg;
        off_next    = off_reg;
        case (cmd.op)
            CH_TICK:
            begin
                if (active_reg && reached(cmd.now, end_reg))
                    active_next = 1'b0;
            end
            CH_FIRE:
            begin
                if (fire_ok)
                begin
                    active_next = 1'b1;
                    end_next    = fire_end;
                    hold_next   = fire_end + sat_ticks(off_reg);
                end
            end
            CH_STOP:
            begin
                active_next = 1'b0;
                end_next    = cmd.now;
                hold_next   = cmd.now + sat_ticks(off_reg);
            end
            CH_SET:
            begin
                on_next  = cmd.on_ticks;
                off_next = cmd.off_ticks;
            end
            CH_SET_IDLE:
            begin
                if (!active_reg)
                begin
                    on_next  = cmd.on_ticks;
                    off_next = cmd.off_ticks;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Hold the channel state; advance it when a transaction is processed.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            end_reg    <= '0;
            hold_reg   <= '0;
            on_reg     <= ON_RESET;
            off_reg    <= OFF_RESET;
        end
        else if (en)
        begin
            active_reg <= active_next;
            end_reg    <= end_next;
            hold_reg   <= hold_next;
            on_reg     <= on_next;
            off_reg    <= off_next;
        end
    end

endmodule
`default_nettype wire

// File: rtl/multichannel_pulse_with_lockout.sv
// Top level of the multichannel one-shot pulse generator with hold-off.
//
// Input stream (s_*): one request per transaction. s_tuser carries the
// action code (tick, fire, stop, set timing, set all idle, fire all, stop
// all); s_tdata carries channel, on_ticks and off_ticks.
// Output stream (m_*): exactly one result per request, holding the pin
// levels, the channels whose fire started a pulse, and the tick counter.
// Flow: an accepted request is held in the input register, then its result
// in the result register, which drives m_*. Throughput: one request per
// cycle while m_tready stays high; all channel updates are done in one
// pass between the input register and the result register.
// Reset: counter, pulse and hold-off times clear, all pins low, on time
// 1000 and off time 9000 ticks on every channel.
// Stall: while m_tready is low the result is held; one further request
// waits in the input register and s_tready drops until the result is taken.
// State changes only when a request moves from the input register into
// the result register, so requests take effect strictly in order.
`default_nettype none
`include "multichannel_pulse_with_lockout_macros.svh"
module multichannel_pulse_with_lockout (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // channel[2:0], on_ticks[18:3], off_ticks[34:19]
    input  wire logic [2:0]  s_tuser,   // action[2:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata    // pin_mask[7:0], accepted_mask[15:8], now_tick[31:16]
);
    import mpl_pkg::*;

    logic      s1_valid_reg;
    logic [2:0] s1_action_reg;
    logic [2:0] s1_channel_reg;
    tick_t     s1_on_reg;
    tick_t     s1_off_reg;
    tick_t     count_reg, count_next;
    tick_t     count_inc;
    logic      out_valid_reg;
    logic [31:0] out_data_reg;
    logic      adv;
    logic      proc;

    chan_cmd_t           cmd [CHANNELS];
    logic [CHANNELS-1:0] active_next;
    logic [CHANNELS-1:0] fire_ok;
    logic [7:0]          pins;
    logic [7:0]          accepted;

    // Move the pipeline when the result register is free or being taken.
    assign adv      = !out_valid_reg || m_tready;
    assign proc     = adv && s1_valid_reg;
    assign s_tready = !s1_valid_reg || adv;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign count_inc  = count_reg + 16'd1;
    assign count_next = (s1_action_reg == ACT_TICK) ? count_inc : count_reg;

    // Decode the request into one operation per channel.
    for (genvar i = 0; i < CHANNELS; i++)
    begin : g_chan
        logic hit;
        assign hit = ({2'b00, s1_channel_reg} == 5'(i));

        always_comb
        begin
            cmd[i].now       = count_reg;
            cmd[i].on_ticks  = s1_on_reg;
            cmd[i].off_ticks = s1_off_reg;
            case (s1_action_reg)
                ACT_TICK:
                begin
                    cmd[i].op  = CH_TICK;
                    cmd[i].now = count_inc;
                end
                ACT_FIRE:     cmd[i].op = hit ? CH_FIRE : CH_NONE;
                ACT_STOP:     cmd[i].op = hit ? CH_STOP : CH_NONE;
                ACT_SET:      cmd[i].op = hit ? CH_SET : CH_NONE;
                ACT_SET_ALL:  cmd[i].op = CH_SET_IDLE;
                ACT_FIRE_ALL: cmd[i].op = CH_FIRE;
                ACT_STOP_ALL: cmd[i].op = CH_STOP;
                default:      cmd[i].op = CH_NONE;
            endcase
        end

        mpl_chan u_chan (
            .clk         (clk),
            .rst_n       (rst_n),
            .en          (proc),
            .cmd         (cmd[i]),
            .active_next (active_next[i]),
            .fire_ok     (fire_ok[i])
        );
    end

    // Map the first eight channels onto the result masks.
    for (genvar j = 0; j < 8; j++)
    begin : g_mask
        if (j < CHANNELS)
        begin : g_used
            assign pins[j]     = active_next[j];
            assign accepted[j] = fire_ok[j];
        end
        else
        begin : g_unused
            assign pins[j]     = 1'b0;
            assign accepted[j] = 1'b0;
        end
    end

    // Hold the input register, counter and result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                s1_valid_reg <= 1'b1;
            else if (adv)
                s1_valid_reg <= 1'b0;
            if (adv)
                out_valid_reg <= s1_valid_reg;
            if (proc)
                count_reg <= count_next;
        end
    end

    // Capture payloads; no reset needed.
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            s1_action_reg  <= s_tuser;
            s1_channel_reg <= s_tdata[2:0];
            s1_on_reg      <= s_tdata[18:3];
            s1_off_reg     <= s_tdata[34:19];
        end
        if (proc)
            out_data_reg <= {count_next, accepted, pins};
    end

    // A channel that just fired is high in the same result.
    `MPL_ASSERT_IMP(a_fired_is_high, m_tvalid, (m_tdata[15:8] & ~m_tdata[7:0]) == 8'd0)
    // A processed tick advances the counter by one.
    `MPL_ASSERT_NXT(a_tick_counts, proc && (s1_action_reg == ACT_TICK),
                    count_reg == $past(count_reg) + 16'd1)
    // Other requests leave the counter alone.
    `MPL_ASSERT_NXT(a_no_tick_hold, proc && (s1_action_reg != ACT_TICK), $stable(count_reg))
    // An empty result register never blocks the input.
    `MPL_ASSERT_IMP(a_ready_when_free, !m_tvalid, s_tready)

endmodule
`default_nettype wire

// File: sim/tb_multichannel_pulse_with_lockout.sv
`timescale 1ns / 100ps
// Testbench of the pulse generator: directed and random requests checked by a scoreboard.
module tb_multichannel_pulse_with_lockout;

    import mpl_pkg::*;

    // Action code with no meaning; the block must leave its state alone
    localparam logic [2:0] ACT_UNUSED = 3'd7;

    // Slowest run: ~530 requests, each with the longest gap and stall, taken several times
    localparam int unsigned CYCLE_LIMIT = 200_000;

    // Fields of one result, first field in the highest bits of m_tdata
    typedef struct packed {
        tick_t      now;
        logic [7:0] fired;
        logic [7:0] pins;
    } pulse_result_t;

    class pulse_scoreboard;
        tick_t         now_cnt;
        bit            live [CHANNELS];
        tick_t         end_at [CHANNELS];
        tick_t         hold_until [CHANNELS];
        tick_t         on_len [CHANNELS];
        tick_t         off_len [CHANNELS];
        pulse_result_t expected_results [$];
        int            errors;
        int            checked;
        int            pulses_started;
        int            fires_refused;

        function new();
            now_cnt = '0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                live[i]       = 1'b0;
                end_at[i]     = '0;
                hold_until[i] = '0;
                on_len[i]     = ON_RESET;
                off_len[i]    = OFF_RESET;
            end
            errors         = 0;
            checked        = 0;
            pulses_started = 0;
            fires_refused  = 0;
        endfunction

        // Clamp an interval to the longest allowed one
        function tick_t clamp(tick_t v);
            return (v > TICK_SAT) ? TICK_SAT : v;
        endfunction

        // Wrap-aware compare: a has reached b when a - b is not negative
        function bit has_reached(tick_t a, tick_t b);
            tick_t d;
            d = a - b;
            return !d[TICK_W-1];
        endfunction

        // Start a pulse if the hold-off has run out
        function bit try_fire(int ch);
            if (!has_reached(now_cnt, hold_until[ch]))
            begin
                fires_refused++;
                return 1'b0;
            end
            live[ch]       = 1'b1;
            end_at[ch]     = now_cnt + clamp(on_len[ch]);
            hold_until[ch] = end_at[ch] + clamp(off_len[ch]);
            pulses_started++;
            return 1'b1;
        endfunction

        // End a pulse now and restart the hold-off from the current tick
        function void halt(int ch);
            live[ch]       = 1'b0;
            end_at[ch]     = now_cnt;
            hold_until[ch] = now_cnt + clamp(off_len[ch]);
        endfunction

        // Advance the predicted state by one accepted request and queue its result
        function void apply_request(logic [2:0] act, logic [2:0] ch, tick_t on_t, tick_t off_t);
            pulse_result_t res;
            res = '0;
            case (act)
                ACT_TICK:
                begin
                    now_cnt++;
                    for (int i = 0; i < CHANNELS; i++)
                        if (live[i] && has_reached(now_cnt, end_at[i]))
                            live[i] = 1'b0;
                end
                ACT_FIRE:
                    if (ch < CHANNELS && try_fire(ch))
                        res.fired[ch] = 1'b1;
                ACT_STOP:
                    if (ch < CHANNELS)
                        halt(ch);
                ACT_SET:
                    if (ch < CHANNELS)
                    begin
                        on_len[ch]  = on_t;
                        off_len[ch] = off_t;
                    end
                ACT_SET_ALL:
                    for (int i = 0; i < CHANNELS; i++)
                        if (!live[i])
                        begin
                            on_len[i]  = on_t;
                            off_len[i] = off_t;
                        end
                ACT_FIRE_ALL:
                    for (int i = 0; i < CHANNELS; i++)
                        if (try_fire(i) && i < 8)
                            res.fired[i] = 1'b1;
                ACT_STOP_ALL:
                    for (int i = 0; i < CHANNELS; i++)
                        halt(i);
                default:
                    ;
            endcase
            for (int i = 0; i < CHANNELS && i < 8; i++)
                res.pins[i] = live[i];
            res.now = now_cnt;
            expected_results.push_back(res);
        endfunction

        // Compare one result with the oldest expectation
        function void check_result(logic [31:0] data);
            pulse_result_t got;
            pulse_result_t want;
            got = data;
            checked++;
            if (expected_results.size() == 0)
            begin
                $error("result %h arrived with no request outstanding", data);
                errors++;
                return;
            end
            want = expected_results.pop_front();
            if (got.pins !== want.pins)
            begin
                $error("pin_mask: expected %h, actual %h", want.pins, got.pins);
                errors++;
            end
            if (got.fired !== want.fired)
            begin
                $error("accepted_mask: expected %h, actual %h", want.fired, got.fired);
                errors++;
            end
            if (got.now !== want.now)
            begin
                $error("now_tick: expected %0d, actual %0d", want.now, got.now);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;    // channel[2:0], on_ticks[18:3], off_ticks[34:19]
    logic [2:0]  s_tuser;    // action[2:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;    // pin_mask[7:0], accepted_mask[15:8], now_tick[31:16]

    pulse_scoreboard sb;
    bit              calm;
    int              requests;
    int unsigned     cycles;

    multichannel_pulse_with_lockout dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Clock
    initial clk = 1'b0;
    always #1 clk = ~clk;

    // Idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Interval for a timing request: mostly short so pulses end and hold-offs expire
    function automatic tick_t pick_time();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7)
            return tick_t'($urandom_range(0, 40));
        if (r < 9)
            return tick_t'($urandom);
        return tick_t'($urandom_range(59990, 65535));
    endfunction

    // Present one request from a falling edge and hold it until the block takes it
    task automatic send_request(input logic [2:0] act, input logic [2:0] ch,
                                input tick_t on_t, input tick_t off_t);
        int gap;
        gap = calm ? 0 : pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {5'b0, off_t, on_t, ch};
        do
            @(posedge clk);
        while (!s_tready);
        sb.apply_request(act, ch, on_t, off_t);
        requests++;
        @(negedge clk);
    endtask

    // Hold the sender until every outstanding result has come back
    task automatic drain();
        while (sb.expected_results.size() != 0)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
    endtask

    // Result side: stall at random, never while calm
    initial
    begin : result_sink
        int stall;
        stall    = 0;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall > 0 && !calm)
            begin
                m_tready <= 1'b0;
                stall--;
            end
            else
            begin
                m_tready <= 1'b1;
                stall = ($urandom_range(0, 4) == 0) ? pick_gap() : 0;
            end
        end
    end

    // Check every result transaction
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    // Bound the run
    initial
    begin : watchdog
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Verification failed");
        $finish;
    end

    initial
    begin : stimulus
        int   kind;
        int   run;
        sb       = new();
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tuser  = '0;
        s_tdata  = '0;
        calm     = 1'b0;
        requests = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: fire, refusal, zero timing, restart, stop on idle, saturation
        send_request(ACT_FIRE, 3'd0, 16'h0000, 16'hFFFF);
        send_request(ACT_FIRE, 3'd0, 16'hFFFF, 16'h0000);
        send_request(ACT_SET, 3'd1, 16'd0, 16'd0);
        send_request(ACT_FIRE, 3'd1, 16'd0, 16'd0);
        send_request(ACT_TICK, 3'd7, 16'hFFFF, 16'hFFFF);
        send_request(ACT_FIRE, 3'd1, 16'd0, 16'd0);
        send_request(ACT_FIRE, 3'd1, 16'd0, 16'd0);
        send_request(ACT_STOP, 3'd2, 16'd0, 16'd0);
        send_request(ACT_FIRE, 3'd2, 16'd0, 16'd0);
        send_request(ACT_SET, 3'd3, 16'hFFFF, 16'hFFFF);
        send_request(ACT_FIRE, 3'd3, 16'd0, 16'd0);
        send_request(ACT_SET, 3'd7, 16'd0, 16'hFFFF);
        send_request(ACT_FIRE, 3'd7, 16'd0, 16'd0);
        send_request(ACT_STOP, 3'd7, 16'd0, 16'd0);
        send_request(ACT_SET_ALL, 3'd0, 16'd60001, 16'd60000);
        send_request(ACT_FIRE_ALL, 3'd0, 16'd0, 16'd0);
        send_request(ACT_UNUSED, 3'd5, 16'hA5A5, 16'h5A5A);
        send_request(ACT_STOP_ALL, 3'd0, 16'd0, 16'd0);
        send_request(ACT_SET_ALL, 3'd0, 16'd2, 16'd0);
        send_request(ACT_FIRE_ALL, 3'd0, 16'd0, 16'd0);
        send_request(ACT_TICK, 3'd0, 16'd0, 16'd0);
        send_request(ACT_TICK, 3'd0, 16'd0, 16'd0);
        send_request(ACT_TICK, 3'd0, 16'd0, 16'd0);
        drain();

        // Random: timing, fire and stop mixed with runs of ticks
        for (int phase = 0; phase < 2; phase++)
        begin
            run = requests + 250;
            while (requests < run)
            begin
                kind = $urandom_range(0, 99);
                if (kind < 4)
                    calm = !calm;
                if (kind < 42)
                    repeat ($urandom_range(1, 30))
                        send_request(ACT_TICK, 3'($urandom), 16'($urandom), 16'($urandom));
                else if (kind < 62)
                    send_request(ACT_FIRE, 3'($urandom), 16'($urandom), 16'($urandom));
                else if (kind < 70)
                    send_request(ACT_STOP, 3'($urandom), 16'($urandom), 16'($urandom));
                else if (kind < 81)
                    send_request(ACT_SET, 3'($urandom), pick_time(), pick_time());
                else if (kind < 85)
                    send_request(ACT_SET_ALL, 3'($urandom), pick_time(), pick_time());
                else if (kind < 90)
                    send_request(ACT_FIRE_ALL, 3'($urandom), 16'($urandom), 16'($urandom));
                else if (kind < 93)
                    send_request(ACT_STOP_ALL, 3'($urandom), 16'($urandom), 16'($urandom));
                else if (kind < 96)
                    send_request(ACT_UNUSED, 3'($urandom), 16'($urandom), 16'($urandom));
                else
                    drain();
            end
            calm = 1'b0;
            drain();
        end

        // Let any stray result show up
        repeat (20) @(negedge clk);

        $display("Ran %0d requests through %0d results in %0d cycles, under random gaps and stalls.",
                 requests, sb.checked, cycles);
        $display("Pulses started: %0d, fires refused by hold-off: %0d, mismatches: %0d.",
                 sb.pulses_started, sb.fires_refused, sb.errors);
        if (sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
